// ===== rtl/core/e2q_pkg.sv =====
// Package for the Euler-to-quaternion pipeline.
// Holds the CORDIC constants, datapath widths and the arctangent table.
// Depends on nothing; the top level and the CORDIC lane import it.
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

	// Number of CORDIC micro-rotations, one register stage each.
	localparam int CORDIC_STAGES = 24;

	// CORDIC angle accumulator and vector component widths.
	// The phase uses 2^32 as one full turn; half angles reach a quarter turn.
	localparam int Z_W  = 34;
	localparam int XY_W = 33;
	// Width of the sine and cosine words that enter the multipliers.
	localparam int MUL_W = 32;
	// Width of a double product and of the sum of two of them.
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W  = PROD_W + 1;
	// Fraction bits of the sine and cosine words.
	localparam int TRIG_FRAC = 30;

	// CORDIC gain compensation 0.60725293500888 in units of 2^-30.
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	typedef logic signed [Z_W-1:0]   cordic_z_t;
	typedef logic signed [XY_W-1:0]  cordic_xy_t;
	typedef logic signed [MUL_W-1:0] trig_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// Arctangent of 2^-i in units where 2^32 is one full turn.
	function automatic cordic_z_t atan_step(input int idx);
		logic [31:0] t;
		case (idx)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			default: t = 32'h00000000;
		endcase
		return cordic_z_t'({1'b0, t});
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2q_angle_if.sv =====
// Input channel of the Euler-to-quaternion block: three binary angles.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface e2q_angle_if #(
	parameter int ANGLE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;

	modport source (output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink (input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/e2q_quat_if.sv =====
// Output channel of the Euler-to-quaternion block: one unit quaternion.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface e2q_quat_if #(
	parameter int FRAC_BITS = 15
);
	logic                      valid;
	logic                      ready;
	logic signed [FRAC_BITS:0] quat_w;
	logic signed [FRAC_BITS:0] quat_x;
	logic signed [FRAC_BITS:0] quat_y;
	logic signed [FRAC_BITS:0] quat_z;

	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/euler_to_quaternion_top.sv =====
// Top level of the Euler-to-quaternion (ZYX) converter.
// Depends on e2q_pkg, e2q_angle_if, e2q_quat_if and e2q_cordic.
//
//   channel  direction  transaction contents
//   angles   in         roll_angle, pitch_angle, yaw_angle (binary angles)
//   quat     out        quat_w, quat_x, quat_y, quat_z (signed Q1.FRAC_BITS)
//
// The pipeline has one phase stage, 24 CORDIC stages, two multiplier
// stages and the rounding stage, whose register is the output register.
// One transaction is accepted every cycle while the output is taken.
// The pipeline moves as one: it holds only when its last stage is full and
// not taken, so no transaction is lost or repeated during a stall.
// Reset clears the valid bits only; the data registers keep no reset.
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion_top #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	e2q_angle_if.sink  angles,
	e2q_quat_if.source quat
);
	import e2q_pkg::*;

	localparam int NSTG   = CORDIC_STAGES + 4;
	localparam int S_CORD = CORDIC_STAGES + 1;
	localparam int RES_W  = FRAC_BITS + 5;

	logic            en;
	logic [NSTG-1:0] valid_q;

	// Whole pipeline advances unless the output holds an untaken result.
	assign en           = !valid_q[NSTG-1] || quat.ready;
	assign angles.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NSTG-2:0], angles.valid};
		end
	end

	// Half-angle phases; pitch is negated and a half turn is kept unwrapped.
	cordic_z_t ph_roll, ph_pitch, ph_yaw;
	cordic_z_t phase_r_s1, phase_p_s1, phase_y_s1;

	assign ph_roll  = Z_W'(angles.roll_angle) <<< (31 - ANGLE_BITS);
	assign ph_pitch = (-Z_W'(angles.pitch_angle)) <<< (31 - ANGLE_BITS);
	assign ph_yaw   = Z_W'(angles.yaw_angle) <<< (31 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_r_s1 <= ph_roll;
			phase_p_s1 <= ph_pitch;
			phase_y_s1 <= ph_yaw;
		end
	end

	// Three CORDIC lanes run side by side.
	trig_t cr, sr, cp, sp, cy, sy;

	e2q_cordic u_cordic_roll (.clk(clk), .en(en), .phase(phase_r_s1),
		.cos_out(cr), .sin_out(sr));
	e2q_cordic u_cordic_pitch (.clk(clk), .en(en), .phase(phase_p_s1),
		.cos_out(cp), .sin_out(sp));
	e2q_cordic u_cordic_yaw (.clk(clk), .en(en), .phase(phase_y_s1),
		.cos_out(cy), .sin_out(sy));

	// Roll-pitch products, rounded back to 30 fraction bits.
	trig_t ab_s26 [4];
	trig_t cy_s26, sy_s26;
	prod_t ab_full [4];
	prod_t ab_rnd [4];

	assign ab_full[0] = PROD_W'(cr) * PROD_W'(cp);
	assign ab_full[1] = PROD_W'(sr) * PROD_W'(sp);
	assign ab_full[2] = PROD_W'(sr) * PROD_W'(cp);
	assign ab_full[3] = PROD_W'(cr) * PROD_W'(sp);

	for (genvar k = 0; k < 4; k++) begin : g_ab
		assign ab_rnd[k] = (ab_full[k] + (PROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				ab_s26[k] <= ab_rnd[k][MUL_W-1:0];
			end
			cy_s26 <= cy;
			sy_s26 <= sy;
		end
	end

	// Triple products, two for each quaternion part.
	prod_t tri_s27 [8];

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s27[0] <= PROD_W'(ab_s26[0]) * PROD_W'(cy_s26);
			tri_s27[1] <= PROD_W'(ab_s26[1]) * PROD_W'(sy_s26);
			tri_s27[2] <= PROD_W'(ab_s26[2]) * PROD_W'(cy_s26);
			tri_s27[3] <= PROD_W'(ab_s26[3]) * PROD_W'(sy_s26);
			tri_s27[4] <= PROD_W'(ab_s26[3]) * PROD_W'(cy_s26);
			tri_s27[5] <= PROD_W'(ab_s26[2]) * PROD_W'(sy_s26);
			tri_s27[6] <= PROD_W'(ab_s26[0]) * PROD_W'(sy_s26);
			tri_s27[7] <= PROD_W'(ab_s26[1]) * PROD_W'(cy_s26);
		end
	end

	// Sum or difference, round half up, saturate to Q1.FRAC_BITS.
	logic signed [FRAC_BITS:0] q_s28 [4];
	logic signed [FRAC_BITS:0] q_next [4];

	for (genvar k = 0; k < 4; k++) begin : g_fin
		sum_t                    s;
		sum_t                    r;
		logic signed [RES_W-1:0] v;
		localparam logic signed [RES_W-1:0] HI = RES_W'((1 << FRAC_BITS) - 1);
		localparam logic signed [RES_W-1:0] LO = -RES_W'(1 << FRAC_BITS);

		if (k == 0 || k == 2) begin : g_add
			assign s = SUM_W'(tri_s27[2*k]) + SUM_W'(tri_s27[2*k+1]);
		end else begin : g_sub
			assign s = SUM_W'(tri_s27[2*k]) - SUM_W'(tri_s27[2*k+1]);
		end
		assign r = s + (SUM_W'(1) <<< (59 - FRAC_BITS));
		assign v = r[SUM_W-1:60-FRAC_BITS];

		always_comb begin
			if (v > HI) begin
				q_next[k] = HI[FRAC_BITS:0];
			end else if (v < LO) begin
				q_next[k] = LO[FRAC_BITS:0];
			end else begin
				q_next[k] = v[FRAC_BITS:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				q_s28[k] <= q_next[k];
			end
		end
	end

	assign quat.valid  = valid_q[NSTG-1];
	assign quat.quat_w = q_s28[0];
	assign quat.quat_x = q_s28[1];
	assign quat.quat_y = q_s28[2];
	assign quat.quat_z = q_s28[3];

	// S_CORD marks the stage where the CORDIC results appear.
	if (S_CORD != NSTG - 3) begin : g_bad_depth
		$error("Pipeline depth mismatch");
	end

endmodule

`default_nettype wire

// ===== rtl/core/e2q_cordic.sv =====
// One pipelined CORDIC lane in rotation mode: phase in, cosine and sine out.
// One micro-rotation per register stage; depends on e2q_pkg.
`timescale 1ns / 1ps
`default_nettype none

module e2q_cordic (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire e2q_pkg::cordic_z_t phase,
	output e2q_pkg::trig_t       cos_out,
	output e2q_pkg::trig_t       sin_out
);
	import e2q_pkg::*;

	// Index 0 is the combinational entry; index i is the register after stage i-1.
	cordic_xy_t x_s [CORDIC_STAGES+1];
	cordic_xy_t y_s [CORDIC_STAGES+1];
	cordic_z_t  z_s [CORDIC_STAGES+1];

	assign x_s[0] = CORDIC_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = phase;

	// Each stage rotates toward zero residual angle by atan(2^-i).
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		cordic_xy_t dx;
		cordic_xy_t dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_step(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_step(i);
				end
			end
		end
	end

	// The residual angle of the last stage is not needed.
	assign cos_out = x_s[CORDIC_STAGES][MUL_W-1:0];
	assign sin_out = y_s[CORDIC_STAGES][MUL_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/e2q_checker.sv =====
// Port-level checks for the Euler-to-quaternion top level, bound to it.
// Depends only on the top level's port signals.
`timescale 1ns / 1ps
`default_nettype none

module e2q_checker #(
	parameter int FRAC_BITS = 15
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [4*(FRAC_BITS+1)-1:0] out_data
);

	// A result that is offered stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output transaction dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("Output transaction changed while stalled");

	// When the output is taken the whole pipeline moves, so input is accepted.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("Input stalled while output is free");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("Result offered during reset");

	// An empty output stage always lets input in.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled with empty output stage");

endmodule

bind euler_to_quaternion_top e2q_checker #(.FRAC_BITS(FRAC_BITS)) u_e2q_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (angles.ready),
	.out_valid(quat.valid),
	.out_ready(quat.ready),
	.out_data ({quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z})
);

`default_nettype wire
